[hdl/ddo_pkg.sv]
// shared types, constants and helper functions of the odometry block
// no dependencies; compile first
package ddo_pkg;

    localparam logic signed [32:0] CORDIC_K = 33'sd652032874;
    localparam int CORDIC_IDX_W = 5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_HEAD,
        S_WAIT1,
        S_WAIT2,
        S_MX,
        S_MY,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        CFG_DIST_PER_TICK = 2'd0,
        CFG_AXLE_LENGTH   = 2'd1,
        CFG_HEAD_PER_DIFF = 2'd2,
        CFG_UNUSED        = 2'd3
    } t_cfg_idx;

    // request to the sine/cosine unit
    typedef struct packed {
        logic        start;
        logic [31:0] angle;
    } t_cor_req;

    // request to the divider
    typedef struct packed {
        logic               start;
        logic signed [40:0] num;
        logic signed [17:0] den;
    } t_div_req;

    function automatic logic [31:0] f_atan(input logic [CORDIC_IDX_W-1:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10680862;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            5'd31: v = 32'd0;
        endcase
        return v;
    endfunction

    // clamp a wrapped count difference to +/-32767
    function automatic logic signed [15:0] f_sat_delta(input logic signed [31:0] v);
        logic signed [15:0] r;
        if (v > 32'sd32767) begin
            r = 16'sd32767;
        end else if (v < -32'sd32767) begin
            r = -16'sd32767;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [40:0] v);
        logic signed [31:0] r;
        if (v > 41'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -41'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[hdl/ddo_in_if.sv]
// input channel: cumulative left and right encoder counts
// no dependencies
interface ddo_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;

    modport source (output valid, left_count, right_count, input ready);
    modport sink   (input valid, left_count, right_count, output ready);
endinterface

[hdl/ddo_out_if.sv]
// output channel: pose after each step
// no dependencies
interface ddo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;
    logic signed [31:0] heading;
    logic               straight_move;

    modport source (output valid, x_pos, y_pos, heading, straight_move, input ready);
    modport sink   (input valid, x_pos, y_pos, heading, straight_move, output ready);
endinterface

[hdl/ddo_cordic.sv]
// rotation-mode cordic, one micro-rotation per cycle, sin/cos in q1.30
// depends on ddo_pkg
module ddo_cordic #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ddo_pkg::t_cor_req   i_req,
    output logic                o_busy,
    output logic signed [32:0]  o_sin,
    output logic signed [32:0]  o_cos
);
    import ddo_pkg::*;

    localparam int CW = $clog2(CORDIC_STEPS);

    logic                r_busy;
    logic                r_flip;
    logic signed [32:0]  r_x;
    logic signed [32:0]  r_y;
    logic signed [33:0]  r_z;
    logic [CW-1:0]       r_i;

    logic signed [31:0]  ang_s;
    logic                flip;
    logic [31:0]         ang_f;
    logic signed [32:0]  dx;
    logic signed [32:0]  dy;
    logic signed [33:0]  at;

    always_comb begin
        ang_s = signed'(i_req.angle);
        flip  = (ang_s > 32'sd1073741824) || (ang_s < -32'sd1073741824);
        // half a turn away: flip the top bit
        ang_f = flip ? {~i_req.angle[31], i_req.angle[30:0]} : i_req.angle;
        dx    = r_y >>> r_i;
        dy    = r_x >>> r_i;
        at    = signed'({2'b00, f_atan(CORDIC_IDX_W'(r_i))});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_i == CW'(CORDIC_STEPS - 1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_flip <= flip;
            r_x    <= CORDIC_K;
            r_y    <= '0;
            r_z    <= {{2{ang_f[31]}}, ang_f};
            r_i    <= '0;
        end else if (r_busy) begin
            if (!r_z[33]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end
            r_i <= r_i + 1'b1;
        end
    end

    assign o_busy = r_busy;
    assign o_sin  = r_flip ? -r_y : r_y;
    assign o_cos  = r_flip ? -r_x : r_x;

endmodule

[hdl/ddo_div.sv]
// restoring signed divider, one quotient bit per cycle, truncates toward zero
// depends on ddo_pkg
module ddo_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ddo_pkg::t_div_req   i_req,
    output logic                o_busy,
    output logic signed [40:0]  o_quo
);
    import ddo_pkg::*;

    logic         r_busy;
    logic         r_neg;
    logic [39:0]  r_q;
    logic [16:0]  r_rem;
    logic [16:0]  r_den;
    logic [5:0]   r_cnt;

    logic [40:0]  num_mag;
    logic [17:0]  den_mag;
    logic [17:0]  sh;
    logic [18:0]  trial;

    always_comb begin
        num_mag = i_req.num[40] ? 41'(-i_req.num) : 41'(i_req.num);
        den_mag = i_req.den[17] ? 18'(-i_req.den) : 18'(i_req.den);
        sh      = {r_rem, r_q[39]};
        trial   = {1'b0, sh} - {2'b00, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == 6'd39) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.num[40] ^ i_req.den[17];
            r_q   <= num_mag[39:0];
            r_rem <= '0;
            r_den <= den_mag[16:0];
            r_cnt <= '0;
        end else if (r_busy) begin
            if (!trial[18]) begin
                r_rem <= trial[16:0];
                r_q   <= {r_q[38:0], 1'b1};
            end else begin
                r_rem <= sh[16:0];
                r_q   <= {r_q[38:0], 1'b0};
            end
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_neg ? -signed'({1'b0, r_q}) : signed'({1'b0, r_q});

endmodule

[hdl/differential_drive_odometry_unit.sv]
// differential-drive odometry, arc model, fixed-point pose
// depends on ddo_pkg, ddo_in_if, ddo_out_if, ddo_cordic, ddo_div
//
// Takes one beat of cumulative left/right encoder counts at a time and returns one beat
// with the updated pose (x, y in signed q16.16 metres, heading as a 32-bit binary angle)
// and a flag for a straight step. Deltas are clamped to +/-32767 ticks. The block works
// on one beat at a time. The one cordic unit runs once for the old heading and, on a
// turn, once more for the new heading. The radius division runs beside the cordic and
// only sets the time when CORDIC_STEPS is small. One registered multiplier serves all
// products. A finished pose waits in an output register, so the input side is ready
// again as soon as the pose is written there; the final state holds while the previous
// pose is still unread.
// Configuration writes are taken at any time but should only be made while no beat is in
// flight.
module differential_drive_odometry_unit #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    ddo_in_if.sink       i_in,
    ddo_out_if.source    o_out
);
    import ddo_pkg::*;

    t_state r_state, n_state;

    // configuration
    logic [31:0] r_dpt;
    logic [23:0] r_axle;
    logic [23:0] r_hptd;

    // pose and last counts
    logic [31:0]        r_last_l, r_last_r;
    logic signed [31:0] r_px, r_py;
    logic [31:0]        r_hd;

    // per-beat working registers
    logic signed [15:0] r_dl, r_dr;
    logic               r_straight;
    logic signed [31:0] r_disp;
    logic [31:0]        r_nh;
    logic signed [32:0] r_s0, r_c0, r_s1, r_c1;
    logic signed [31:0] r_rad;
    logic signed [31:0] r_nx;
    logic signed [67:0] r_prod;

    // output register
    logic               r_ov;
    logic signed [31:0] r_ox, r_oy, r_oh;
    logic               r_os;

    logic               acc;
    logic               fin_go;
    logic signed [15:0] dl_in, dr_in;
    logic signed [16:0] sum, diff, absdiff;
    logic signed [33:0] m_a, m_b;
    logic               mul_en;
    logic signed [67:0] rnd16, rnd30;
    logic [31:0]        dth;
    logic signed [40:0] x_sum, y_sum;

    t_cor_req           cor_req;
    logic               cor_busy;
    logic signed [32:0] cor_sin, cor_cos;
    t_div_req           div_req;
    logic               div_busy;
    logic signed [40:0] div_quo;

    ddo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cor_req),
        .o_busy  (cor_busy),
        .o_sin   (cor_sin),
        .o_cos   (cor_cos)
    );

    ddo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign acc        = i_in.valid && i_in.ready;
    assign fin_go     = (r_state == S_FIN) && (!r_ov || o_out.ready);

    always_comb begin
        // wrapped count differences, then clamped
        dl_in   = f_sat_delta(signed'(i_in.left_count - r_last_l));
        dr_in   = f_sat_delta(signed'(i_in.right_count - r_last_r));
        sum     = 17'(r_dl) + 17'(r_dr);
        diff    = 17'(r_dr) - 17'(r_dl);
        absdiff = diff[16] ? -diff : diff;
        rnd16   = r_prod + 68'sd32768;
        rnd30   = r_prod + 68'sd536870912;
        dth     = diff[16] ? -r_prod[31:0] : r_prod[31:0];
        x_sum   = 41'(r_px) + 41'(signed'(rnd30[67:30]));
        y_sum   = r_straight ? 41'(r_py) + 41'(signed'(rnd30[67:30]))
                             : 41'(r_py) - 41'(signed'(rnd30[67:30]));
    end

    // shared multiplier operand select
    always_comb begin
        m_a    = '0;
        m_b    = '0;
        mul_en = 1'b1;
        unique case (r_state)
            S_MUL1: begin
                if (r_straight) begin
                    m_a = 34'(r_dl);
                    m_b = signed'({2'b00, r_dpt});
                end else begin
                    m_a = 34'(sum);
                    m_b = signed'({10'd0, r_axle});
                end
            end
            S_MUL2: begin
                m_a = 34'(absdiff);
                m_b = signed'({10'd0, r_hptd});
            end
            S_MX: begin
                if (r_straight) begin
                    m_a = 34'(r_disp);
                    m_b = 34'(r_c0);
                end else begin
                    m_a = 34'(r_rad);
                    m_b = 34'(r_s1) - 34'(r_s0);
                end
            end
            S_MY: begin
                if (r_straight) begin
                    m_a = 34'(r_disp);
                    m_b = 34'(r_s0);
                end else begin
                    m_a = 34'(r_rad);
                    m_b = 34'(r_c1) - 34'(r_c0);
                end
            end
            default: mul_en = 1'b0;
        endcase
    end

    // sequencer
    always_comb begin
        n_state       = r_state;
        cor_req.start = 1'b0;
        cor_req.angle = (r_state == S_IDLE) ? r_hd : r_nh;
        div_req.start = 1'b0;
        div_req.num   = r_prod[40:0];
        div_req.den   = {diff, 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    cor_req.start = 1'b1;
                    n_state       = S_MUL1;
                end
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: begin
                if (r_straight) begin
                    n_state = S_WAIT1;
                end else begin
                    div_req.start = 1'b1;
                    n_state       = S_HEAD;
                end
            end
            S_HEAD: n_state = S_WAIT1;
            S_WAIT1: begin
                if (!cor_busy) begin
                    if (r_straight) begin
                        n_state = S_MX;
                    end else begin
                        cor_req.start = 1'b1;
                        n_state       = S_WAIT2;
                    end
                end
            end
            S_WAIT2: begin
                if (!cor_busy && !div_busy) begin
                    n_state = S_MX;
                end
            end
            S_MX: n_state = S_MY;
            S_MY: n_state = S_FIN;
            S_FIN: begin
                if (fin_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration, state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dpt    <= 32'd110355;
            r_axle   <= 24'd4391;
            r_hptd   <= 24'd262144;
            r_last_l <= '0;
            r_last_r <= '0;
            r_px     <= '0;
            r_py     <= '0;
            r_hd     <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_DIST_PER_TICK: r_dpt  <= i_cfg_data;
                    CFG_AXLE_LENGTH:   r_axle <= i_cfg_data[23:0];
                    CFG_HEAD_PER_DIFF: r_hptd <= i_cfg_data[23:0];
                    CFG_UNUSED:        ;
                endcase
            end
            if (acc) begin
                r_last_l <= i_in.left_count;
                r_last_r <= i_in.right_count;
            end
            if (fin_go) begin
                r_px <= r_nx;
                r_py <= f_sat32(y_sum);
                if (!r_straight) begin
                    r_hd <= r_nh;
                end
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= m_a * m_b;
        end
        if (acc) begin
            r_dl       <= dl_in;
            r_dr       <= dr_in;
            r_straight <= (dl_in == dr_in);
        end
        if (r_state == S_MUL2) begin
            // straight travel in q16.16, rounded half up
            r_disp <= rnd16[47:16];
        end
        if (r_state == S_HEAD) begin
            r_nh <= r_hd + dth;
        end
        if (r_state == S_WAIT1 && !cor_busy) begin
            r_s0 <= cor_sin;
            r_c0 <= cor_cos;
        end
        if (r_state == S_WAIT2 && !cor_busy && !div_busy) begin
            r_s1  <= cor_sin;
            r_c1  <= cor_cos;
            r_rad <= f_sat32(div_quo);
        end
        if (r_state == S_MY) begin
            r_nx <= f_sat32(x_sum);
        end
        if (fin_go) begin
            r_ox <= r_nx;
            r_oy <= f_sat32(y_sum);
            r_oh <= r_straight ? r_hd : r_nh;
            r_os <= r_straight;
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.x_pos         = r_ox;
    assign o_out.y_pos         = r_oy;
    assign o_out.heading       = r_oh;
    assign o_out.straight_move = r_os;

`ifndef NO_ASSERTIONS
    // the cordic is never restarted mid-sweep
    a_cor_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cor_req.start |-> !cor_busy)
        else $error("cordic started while busy");

    // the radius is settled before the position products
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MX) |-> !div_busy)
        else $error("divider still busy at position update");

    // a straight step leaves the heading alone
    a_head_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_go && r_straight) |=> (r_hd == $past(r_hd)))
        else $error("heading changed on straight step");
`endif

endmodule

[test/ddo_checker.sv]
// odometry checker: watches the config port and both channels, predicts each pose
// depends on ddo_pkg, ddo_in_if, ddo_out_if
module ddo_checker #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    ddo_in_if           i_in,
    ddo_out_if          i_out,
    output int          o_fail_count,
    output int          o_pending
);
    import ddo_pkg::*;

    typedef struct {
        logic [31:0] x_pos;
        logic [31:0] y_pos;
        logic [31:0] heading;
        logic        straight_move;
    } t_pose;

    localparam longint ARCTAN [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0
    };

    logic [31:0] dist_per_tick;
    logic [23:0] axle_len;
    logic [23:0] turn_per_diff;
    logic [31:0] prev_left, prev_right, pose_x, pose_y, pose_head;
    t_pose       pose_queue [$];

    assign o_pending = pose_queue.size();

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clamp_ticks(input longint v);
        if (v > 32767) return 32767;
        if (v < -32767) return -32767;
        return v;
    endfunction

    function automatic longint round_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // rotation-mode cordic, q1.30 sine and cosine of a binary angle
    task automatic sin_cos(input logic [31:0] ang, output longint s, output longint c);
        longint z, x, y, dx, dy;
        bit     flip;
        z    = longint'($signed(ang));
        flip = 1'b0;
        x    = longint'(CORDIC_K);
        y    = 0;
        if (z > 64'sd1073741824 || z < -64'sd1073741824) begin
            flip = 1'b1;
            z    = longint'($signed(ang - 32'h8000_0000));
        end
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ARCTAN[i];
            end else begin
                x += dx; y -= dy; z += ARCTAN[i];
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endtask

    task automatic predict_pose(input logic [31:0] lc, input logic [31:0] rc);
        longint      dl, dr, px, py, s0, c0, s1, c1, disp, diff, mag, radius;
        logic [31:0] dth, nh;
        t_pose       p;
        dl = clamp_ticks(longint'($signed(lc - prev_left)));
        dr = clamp_ticks(longint'($signed(rc - prev_right)));
        px = longint'($signed(pose_x));
        py = longint'($signed(pose_y));
        prev_left  = lc;
        prev_right = rc;
        sin_cos(pose_head, s0, c0);
        p.straight_move = (dl == dr);
        if (dl == dr) begin
            disp = round_shift(dl * longint'(dist_per_tick), 16);
            px   = clamp32(px + round_shift(disp * c0, 30));
            py   = clamp32(py + round_shift(disp * s0, 30));
        end else begin
            diff   = dr - dl;
            // signed division truncates toward zero
            radius = clamp32(((dr + dl) * longint'(axle_len)) / (2 * diff));
            mag    = (diff < 0) ? -diff : diff;
            dth    = 32'(mag * longint'(turn_per_diff));
            if (diff < 0) dth = 32'd0 - dth;
            nh = pose_head + dth;
            sin_cos(nh, s1, c1);
            px = clamp32(px + round_shift(radius * (s1 - s0), 30));
            py = clamp32(py - round_shift(radius * (c1 - c0), 30));
            pose_head = nh;
        end
        pose_x        = px[31:0];
        pose_y        = py[31:0];
        p.x_pos       = pose_x;
        p.y_pos       = pose_y;
        p.heading     = pose_head;
        pose_queue.push_back(p);
    endtask

    always @(posedge i_clk) begin
        t_pose want;
        if (!i_rst_n) begin
            dist_per_tick <= 32'd110355;
            axle_len      <= 24'd4391;
            turn_per_diff <= 24'd262144;
            prev_left  = '0; prev_right = '0;
            pose_x     = '0; pose_y     = '0; pose_head = '0;
            pose_queue.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DIST_PER_TICK: dist_per_tick <= i_cfg_data;
                    CFG_AXLE_LENGTH:   axle_len      <= i_cfg_data[23:0];
                    CFG_HEAD_PER_DIFF: turn_per_diff <= i_cfg_data[23:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) predict_pose(i_in.left_count, i_in.right_count);
            if (i_out.valid && i_out.ready) begin
                if (pose_queue.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected pose beat at %0t", $realtime);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = pose_queue.pop_front();
                    if (i_out.x_pos !== want.x_pos || i_out.y_pos !== want.y_pos ||
                        i_out.heading !== want.heading ||
                        i_out.straight_move !== want.straight_move) begin
                        if (o_fail_count < 10)
                            $display("pose mismatch at %0t: exp x %0d y %0d h %h s %b,",
                                     $realtime, $signed(want.x_pos), $signed(want.y_pos),
                                     want.heading, want.straight_move,
                                     " got x %0d y %0d h %h s %b", i_out.x_pos,
                                     i_out.y_pos, i_out.heading, i_out.straight_move);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

[test/differential_drive_odometry_unit_tb.sv]
// top of the odometry testbench: clock, reset, encoder stimulus, config phases, verdict
// depends on ddo_pkg, ddo_in_if, ddo_out_if, ddo_checker and the block itself
module differential_drive_odometry_unit_tb;
    import ddo_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending;
    int          beats_sent;
    int          burst_left;
    logic [31:0] cur_left, cur_right;

    ddo_in_if  u_in ();
    ddo_out_if u_out ();

    differential_drive_odometry_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (u_in),
        .o_out      (u_out)
    );

    ddo_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in         (u_in),
        .i_out        (u_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #6000000;
        $display("simulation failed");
        $finish;
    end

    // offer one beat; valid stays high across back-to-back beats inside a burst
    task automatic send_counts(input logic [31:0] l, input logic [31:0] r);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                u_in.valid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        u_in.valid       <= 1'b1;
        u_in.left_count  <= l;
        u_in.right_count <= r;
        cur_left  = l;
        cur_right = r;
        do @(posedge i_clk); while (!u_in.ready);
        beats_sent++;
    endtask

    // relative move from the current counts
    task automatic move_by(input int dl, input int dr);
        send_counts(cur_left + dl, cur_right + dr);
    endtask

    // drain, let the block settle, then write one register
    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        u_in.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // mostly realistic wheel motion, some wild jumps and saturating steps
    task automatic random_motion(input int n);
        int d, pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 19);
            d    = $urandom_range(0, 400) - 200;
            if (pick < 4)       move_by(d, d);
            else if (pick < 14) move_by(d, d + $urandom_range(0, 60) - 30);
            else if (pick < 16) move_by($urandom_range(0, 65534) - 32767,
                                        $urandom_range(0, 65534) - 32767);
            else if (pick < 18) send_counts($urandom, $urandom);
            else                move_by(d, -d);
        end
    endtask

    // receiver: random stalls, calm stretches, one long hold-off to back the block up
    initial begin
        int mode_left;
        bit held_off;
        mode_left = 0;
        held_off  = 1'b0;
        u_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held_off && beats_sent > 300) begin
                held_off = 1'b1;
                u_out.ready <= 1'b0;
                repeat (900) @(posedge i_clk);
            end
            if (mode_left == 0) mode_left = $urandom_range(20, 200);
            mode_left--;
            if (mode_left > 100) u_out.ready <= 1'b1;
            else                 u_out.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial begin
        beats_sent = 0;
        burst_left = 0;
        cur_left   = '0;
        cur_right  = '0;
        i_rst_n          <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_idx          <= CFG_DIST_PER_TICK;
        cfg_data         <= '0;
        u_in.valid       <= 1'b0;
        u_in.left_count  <= '0;
        u_in.right_count <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset config, idle step, straight, turns, saturation, wrap
        send_counts(32'd0, 32'd0);
        move_by(100, 100);
        move_by(50, 150);
        move_by(150, 50);
        move_by(100000, 200000);            // both clamp to the same bound, straight
        move_by(-100000, -300000);
        move_by(40000, -40000);             // opposite clamps, spin on the spot
        send_counts(32'h7fff_ffff, 32'h7fff_ffff);
        send_counts(32'h8000_0000, 32'h8000_0005);   // count wrap
        send_counts(32'hffff_ffff, 32'h0000_0000);
        // zero axle: position holds during a turn
        write_reg(CFG_AXLE_LENGTH, 32'd0);
        move_by(10, 500);
        move_by(-300, 20);
        // largest turn rate and axle length
        write_reg(CFG_HEAD_PER_DIFF, 32'hffff_ffff);
        write_reg(CFG_AXLE_LENGTH, 32'hffff_ffff);
        move_by(0, 1);
        move_by(0, 32767);
        move_by(1, 0);
        // largest wheel travel, drive the position into its bounds
        write_reg(CFG_DIST_PER_TICK, 32'hffff_ffff);
        repeat (3) move_by(32767, 32767);
        repeat (3) move_by(-32767, -32767);
        write_reg(CFG_UNUSED, $urandom);    // ignored index
        move_by(7, 7);

        // random phases under several settings
        random_motion(220);
        write_reg(CFG_DIST_PER_TICK, 32'd0);
        write_reg(CFG_HEAD_PER_DIFF, 32'd0);
        write_reg(CFG_AXLE_LENGTH, 32'd1);
        random_motion(180);
        write_reg(CFG_DIST_PER_TICK, 32'd110355);
        write_reg(CFG_AXLE_LENGTH, 32'd4391);
        write_reg(CFG_HEAD_PER_DIFF, 32'd262144);
        random_motion(220);
        write_reg(CFG_DIST_PER_TICK, $urandom);
        write_reg(CFG_AXLE_LENGTH, $urandom);
        write_reg(CFG_HEAD_PER_DIFF, $urandom);
        random_motion(220);
        write_reg(CFG_DIST_PER_TICK, $urandom_range(0, 2000000));
        write_reg(CFG_AXLE_LENGTH, $urandom_range(1, 20000));
        write_reg(CFG_HEAD_PER_DIFF, $urandom_range(0, 5000000));
        random_motion(240);

        u_in.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
